// ===== sv/assert_macros.svh =====
// Assertion macros shared by the SHA-1 digest RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked while in reset.
`define SHA1MD_ASSERT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("sha1md check failed");

// Implication checked in the next cycle, masked while in reset.
`define SHA1MD_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("sha1md check failed");

`endif

// ===== sv/sha1md_pkg.sv =====
// Shared types and constants for the SHA-1 digest block.
// No dependencies; used by sha1md_sched_mem, sha1md_round and the top level.
`default_nettype none

package sha1md_pkg;

    localparam int LENGTH_COUNTER_BITS_DEF = 61;

    localparam int MEM_DEPTH  = 16;
    localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = 7;
    localparam int DIGEST_WORDS = 5;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // working variables a..e
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } vars_t;

    // one write and two read addresses per cycle
    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [31:0]           wdata;
        logic [MEM_ADDR_W-1:0] raddr0;
        logic [MEM_ADDR_W-1:0] raddr1;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/sha1md_sched_mem.sv =====
// Block buffer and message schedule ring: 16 x 32 synchronous RAM.
// One write port, two registered read ports. Depends on sha1md_pkg.
`default_nettype none

module sha1md_sched_mem (
    input  wire logic                aclk,
    input  wire sha1md_pkg::mem_req_t req,
    output logic [31:0]              rdata0,
    output logic [31:0]              rdata1
);

    logic [31:0] mem [sha1md_pkg::MEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata0 <= mem[req.raddr0];
        rdata1 <= mem[req.raddr1];
    end

endmodule

`default_nettype wire

// ===== sv/sha1md_round.sv =====
// One SHA-1 round: selects f and K by round number, forms the new a..e.
// Depends on sha1md_pkg.
`default_nettype none

module sha1md_round (
    input  wire sha1md_pkg::vars_t           vars_in,
    input  wire logic [31:0]                 w_in,
    input  wire logic [sha1md_pkg::ROUND_W-1:0] rnd_in,
    output sha1md_pkg::vars_t                vars_out
);

    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] a_rot;

    always_comb begin
        priority if (rnd_in < sha1md_pkg::ROUND_W'(20)) begin
            f_val = (vars_in.b & vars_in.c) | (~vars_in.b & vars_in.d);
            k_val = sha1md_pkg::K_00_19;
        end else if (rnd_in < sha1md_pkg::ROUND_W'(40)) begin
            f_val = vars_in.b ^ vars_in.c ^ vars_in.d;
            k_val = sha1md_pkg::K_20_39;
        end else if (rnd_in < sha1md_pkg::ROUND_W'(60)) begin
            f_val = (vars_in.b & vars_in.c) | (vars_in.b & vars_in.d)
                  | (vars_in.c & vars_in.d);
            k_val = sha1md_pkg::K_40_59;
        end else begin
            f_val = vars_in.b ^ vars_in.c ^ vars_in.d;
            k_val = sha1md_pkg::K_60_79;
        end
    end

    assign a_rot = {vars_in.a[26:0], vars_in.a[31:27]};

    always_comb begin
        vars_out.a = a_rot + f_val + vars_in.e + k_val + w_in;
        vars_out.b = vars_in.a;
        vars_out.c = {vars_in.b[1:0], vars_in.b[31:2]};
        vars_out.d = vars_in.c;
        vars_out.e = vars_in.d;
    end

endmodule

`default_nettype wire

// ===== sv/sha1md_top.sv =====
// SHA-1 message digest, one byte per input beat, digest as five word beats.
// Depends on sha1md_pkg, sha1md_sched_mem, sha1md_round, assert_macros.svh.
//
//  channel | dir | tdata              | tuser             | tlast
//  --------+-----+--------------------+-------------------+----------------
//  s_      | in  | [7:0] byte_value   | [0] byte_present  | end_of_message
//  m_      | out | [31:0] digest_word | [2:0] word_index  | last_word
//
// The 64th byte of a block starts a compression: 80 rounds, each spread over
// ST_RA and ST_RB since every round reads four schedule words through the two
// read ports of the block RAM, then a last ST_RA finishes the last round and
// ST_FOLD folds a..e into the chaining value. An end beat writes the padding
// words (after that compression if it carried the 64th byte), one RAM word
// per cycle (up to 16), then compresses once, or twice when the mark leaves
// fewer than 8 bytes for the length (a second padding pass of all 16 words
// comes before the second). s_tready is low for all of a compression, and
// from an end beat until the fifth digest beat is taken; m_ may stall freely.
// Synchronous active-low reset, no RAM clear.
`default_nettype none
`include "assert_macros.svh"

module sha1_message_digest_top #(
    parameter int LENGTH_COUNTER_BITS = sha1md_pkg::LENGTH_COUNTER_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_of_message
    // digest beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [2:0]       m_tuser,   // [2:0] word_index
    output logic             m_tlast    // last_word
);

    localparam int AW = sha1md_pkg::MEM_ADDR_W;
    localparam int RW = sha1md_pkg::ROUND_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_RA,
        ST_RB,
        ST_FOLD,
        ST_OUT
    } state_t;

    // where to go once a compression has folded in
    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_PAD_NEW,
        AFT_PAD2,
        AFT_OUT
    } after_t;

    state_t                       state_reg;
    after_t                       after_reg;
    logic [LENGTH_COUNTER_BITS-1:0] cnt_reg;
    logic [23:0]                  acc_reg;
    logic [31:0]                  chain_reg [sha1md_pkg::DIGEST_WORDS];
    sha1md_pkg::vars_t            vars_reg;
    logic [RW-1:0]                rnd_reg;
    logic                         pend_reg;
    logic [31:0]                  x_reg;
    logic [5:0]                   pad_pos_reg;
    logic [AW-1:0]                pad_idx_reg;
    logic                         pad_second_reg;
    logic [2:0]                   oidx_reg;

    sha1md_pkg::mem_req_t         mem_req;
    logic [31:0]                  rd0;
    logic [31:0]                  rd1;
    sha1md_pkg::vars_t            vars_next;

    logic                         s_accept;
    logic [5:0]                   pos_in;
    logic [5:0]                   pos_after;
    logic [LENGTH_COUNTER_BITS-1:0] cnt_inc;
    logic [63:0]                  bit_len;
    logic [31:0]                  pad_head;
    logic [31:0]                  pad_word;
    logic                         len_here;
    logic [RW-1:0]                rnd_done;
    logic [31:0]                  w_sched;
    logic [31:0]                  w_mix;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pos_in   = cnt_reg[5:0];
    assign cnt_inc  = cnt_reg + LENGTH_COUNTER_BITS'(1);
    assign pos_after = s_tuser ? cnt_inc[5:0] : cnt_reg[5:0];
    assign bit_len  = 64'(cnt_reg) << 3;

    // word holding the 0x80 mark: earlier lanes keep their bytes
    always_comb begin
        unique case (pad_pos_reg[1:0])
            2'd0: pad_head = {sha1md_pkg::PAD_MARK, 24'h0};
            2'd1: pad_head = {acc_reg[23:16], sha1md_pkg::PAD_MARK, 16'h0};
            2'd2: pad_head = {acc_reg[23:8], sha1md_pkg::PAD_MARK, 8'h0};
            default: pad_head = {acc_reg, sha1md_pkg::PAD_MARK};
        endcase
    end

    // length goes into this block unless the mark left under 8 bytes
    assign len_here = pad_second_reg || (pad_pos_reg < 6'd56);

    always_comb begin
        priority if (!pad_second_reg && pad_idx_reg == pad_pos_reg[5:2]) begin
            pad_word = pad_head;
        end else if (len_here && pad_idx_reg == AW'(14)) begin
            pad_word = bit_len[63:32];
        end else if (len_here && pad_idx_reg == AW'(15)) begin
            pad_word = bit_len[31:0];
        end else begin
            pad_word = 32'h0;
        end
    end

    // round completing in ST_RA is the one whose reads went out before
    assign rnd_done = rnd_reg - RW'(1);
    assign w_mix    = x_reg ^ rd0 ^ rd1;
    assign w_sched  = (rnd_done < RW'(sha1md_pkg::MEM_DEPTH)) ? rd1
                                                              : {w_mix[30:0], w_mix[31]};

    // RAM port: pair 1 is W[t-3], W[t-8]; pair 2 is W[t-14], W[t-16].
    // W[t] goes back to slot t while pair 1 of round t+1 is read; the slots
    // never coincide, and every word read was written at least a round ago.
    always_comb begin
        mem_req        = '0;
        mem_req.raddr0 = rnd_reg[AW-1:0] + AW'(sha1md_pkg::MEM_DEPTH - 3);
        mem_req.raddr1 = rnd_reg[AW-1:0] + AW'(sha1md_pkg::MEM_DEPTH - 8);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser && pos_in[1:0] == 2'd3) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_in[5:2];
                    mem_req.wdata = {acc_reg, s_tdata};
                end
            end
            ST_PAD: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pad_idx_reg;
                mem_req.wdata = pad_word;
            end
            ST_RA: begin
                if (pend_reg) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = rnd_done[AW-1:0];
                    mem_req.wdata = w_sched;
                end
            end
            ST_RB: begin
                mem_req.raddr0 = rnd_reg[AW-1:0] + AW'(sha1md_pkg::MEM_DEPTH - 14);
                mem_req.raddr1 = rnd_reg[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    sha1md_sched_mem u_mem (
        .aclk   (aclk),
        .req    (mem_req),
        .rdata0 (rd0),
        .rdata1 (rd1)
    );

    sha1md_round u_round (
        .vars_in  (vars_reg),
        .w_in     (w_sched),
        .rnd_in   (rnd_done),
        .vars_out (vars_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            after_reg      <= AFT_IDLE;
            cnt_reg        <= '0;
            chain_reg[0]   <= sha1md_pkg::H0_INIT;
            chain_reg[1]   <= sha1md_pkg::H1_INIT;
            chain_reg[2]   <= sha1md_pkg::H2_INIT;
            chain_reg[3]   <= sha1md_pkg::H3_INIT;
            chain_reg[4]   <= sha1md_pkg::H4_INIT;
            rnd_reg        <= '0;
            pend_reg       <= 1'b0;
            pad_pos_reg    <= '0;
            pad_idx_reg    <= '0;
            pad_second_reg <= 1'b0;
            oidx_reg       <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser) begin
                            cnt_reg <= cnt_inc;
                            unique case (pos_in[1:0])
                                2'd0: acc_reg <= {s_tdata, 16'h0};
                                2'd1: acc_reg[15:8] <= s_tdata;
                                2'd2: acc_reg[7:0] <= s_tdata;
                                default: begin
                                end
                            endcase
                        end
                        if (s_tuser && pos_in == 6'd63) begin
                            vars_reg  <= {chain_reg[0], chain_reg[1], chain_reg[2],
                                          chain_reg[3], chain_reg[4]};
                            rnd_reg   <= '0;
                            pend_reg  <= 1'b0;
                            after_reg <= s_tlast ? AFT_PAD_NEW : AFT_IDLE;
                            state_reg <= ST_RA;
                        end else if (s_tlast) begin
                            pad_pos_reg    <= pos_after;
                            pad_idx_reg    <= pos_after[5:2];
                            pad_second_reg <= 1'b0;
                            state_reg      <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    pad_idx_reg <= pad_idx_reg + AW'(1);
                    if (pad_idx_reg == AW'(sha1md_pkg::MEM_DEPTH - 1)) begin
                        vars_reg  <= {chain_reg[0], chain_reg[1], chain_reg[2],
                                      chain_reg[3], chain_reg[4]};
                        rnd_reg   <= '0;
                        pend_reg  <= 1'b0;
                        after_reg <= len_here ? AFT_OUT : AFT_PAD2;
                        state_reg <= ST_RA;
                    end
                end
                ST_RA: begin
                    if (pend_reg) begin
                        vars_reg <= vars_next;
                    end
                    if (rnd_reg == RW'(sha1md_pkg::ROUNDS)) begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_FOLD;
                    end else begin
                        state_reg <= ST_RB;
                    end
                end
                ST_RB: begin
                    x_reg     <= rd0 ^ rd1;
                    rnd_reg   <= rnd_reg + RW'(1);
                    pend_reg  <= 1'b1;
                    state_reg <= ST_RA;
                end
                ST_FOLD: begin
                    chain_reg[0] <= chain_reg[0] + vars_reg.a;
                    chain_reg[1] <= chain_reg[1] + vars_reg.b;
                    chain_reg[2] <= chain_reg[2] + vars_reg.c;
                    chain_reg[3] <= chain_reg[3] + vars_reg.d;
                    chain_reg[4] <= chain_reg[4] + vars_reg.e;
                    rnd_reg      <= '0;
                    unique case (after_reg)
                        AFT_IDLE: begin
                            state_reg <= ST_IDLE;
                        end
                        AFT_PAD_NEW: begin
                            // message ended on a block boundary
                            pad_pos_reg    <= '0;
                            pad_idx_reg    <= '0;
                            pad_second_reg <= 1'b0;
                            state_reg      <= ST_PAD;
                        end
                        AFT_PAD2: begin
                            pad_idx_reg    <= '0;
                            pad_second_reg <= 1'b1;
                            state_reg      <= ST_PAD;
                        end
                        default: begin
                            oidx_reg  <= '0;
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                default: begin
                    if (m_tready) begin
                        if (oidx_reg == 3'(sha1md_pkg::DIGEST_WORDS - 1)) begin
                            chain_reg[0] <= sha1md_pkg::H0_INIT;
                            chain_reg[1] <= sha1md_pkg::H1_INIT;
                            chain_reg[2] <= sha1md_pkg::H2_INIT;
                            chain_reg[3] <= sha1md_pkg::H3_INIT;
                            chain_reg[4] <= sha1md_pkg::H4_INIT;
                            cnt_reg      <= '0;
                            oidx_reg     <= '0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            oidx_reg <= oidx_reg + 3'd1;
                        end
                    end
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'(sha1md_pkg::DIGEST_WORDS - 1));

    // no input beat while the digest is being sent
    `SHA1MD_ASSERT(a_no_in_during_out, aclk, aresetn, m_tvalid, !s_tready)
    // schedule write never hits a slot being read in the same round cycle
    `SHA1MD_ASSERT(a_sched_no_clash, aclk, aresetn,
        state_reg == ST_RA && pend_reg && rnd_reg != RW'(sha1md_pkg::ROUNDS),
        mem_req.waddr != mem_req.raddr0 && mem_req.waddr != mem_req.raddr1)
    // after the last digest beat the block is back in its reset state
    `SHA1MD_ASSERT_NEXT(a_restart, aclk, aresetn, m_tvalid && m_tready && m_tlast,
        s_tready && cnt_reg == '0 && chain_reg[0] == sha1md_pkg::H0_INIT)
    // digest words are numbered 0 to 4 only
    `SHA1MD_ASSERT(a_word_index, aclk, aresetn, m_tvalid,
        m_tuser <= 3'(sha1md_pkg::DIGEST_WORDS - 1))

endmodule

`default_nettype wire

// ===== tb/sv/sha1_digest_checker.sv =====
`timescale 1ns / 100ps
// Digest checker for the SHA-1 message digest block: watches both streams,
// predicts the digest beats and compares them. Depends on sha1md_pkg.

module sha1_digest_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
    input  wire logic        s_tuser,   // [0] byte_present
    input  wire logic        s_tlast,   // end_of_message
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [31:0] digest_word
    input  wire logic [2:0]  m_tuser,   // [2:0] word_index
    input  wire logic        m_tlast,   // last_word
    output int               fail_count,
    output int               words_pending
);

    localparam int LEN_BITS = sha1md_pkg::LENGTH_COUNTER_BITS_DEF;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic [31:0]         hash_h [sha1md_pkg::DIGEST_WORDS];
    logic [31:0]         msg_block [sha1md_pkg::MEM_DEPTH];
    logic [LEN_BITS-1:0] byte_count;
    digest_beat_t        digest_q [$];
    digest_beat_t        exp_beat;
    int                  errs;

    function automatic void restart_message();
        hash_h[0]  = sha1md_pkg::H0_INIT;
        hash_h[1]  = sha1md_pkg::H1_INIT;
        hash_h[2]  = sha1md_pkg::H2_INIT;
        hash_h[3]  = sha1md_pkg::H3_INIT;
        hash_h[4]  = sha1md_pkg::H4_INIT;
        byte_count = '0;
    endfunction

    // 80 rounds over msg_block, folded into hash_h
    function automatic void compress_msg_block();
        logic [31:0] w [sha1md_pkg::ROUNDS];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < sha1md_pkg::ROUNDS; i++) begin
            t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int r = 0; r < sha1md_pkg::ROUNDS; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K_00_19;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_20_39;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K_40_59;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_60_79;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    // big-endian lanes; lane 0 clears the rest of the word
    function automatic void place_byte(input logic [5:0] pos, input logic [7:0] value);
        logic [31:0] w;
        w = (pos[1:0] == 2'd0) ? 32'h0 : msg_block[pos[5:2]];
        w |= {24'h0, value} << (24 - 8 * pos[1:0]);
        msg_block[pos[5:2]] = w;
    endfunction

    function automatic void absorb_beat(input logic [7:0] value, input logic present,
                                        input logic eom);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        if (present) begin
            pos = byte_count[5:0];
            place_byte(pos, value);
            byte_count = byte_count + 1'b1;
            if (pos == 6'd63) compress_msg_block();
        end
        if (eom) begin
            pos = byte_count[5:0];
            place_byte(pos, sha1md_pkg::PAD_MARK);
            for (int i = int'(pos[5:2]) + 1; i < 16; i++) msg_block[i] = 32'h0;
            if (pos >= 6'd56) begin
                compress_msg_block();
                for (int i = 0; i < 16; i++) msg_block[i] = 32'h0;
            end
            bit_len       = 64'(byte_count) << 3;
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_msg_block();
            for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++)
                digest_q.push_back('{word: hash_h[i], index: 3'(i),
                                     last: (i == sha1md_pkg::DIGEST_WORDS - 1)});
            restart_message();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_message();
            digest_q.delete();
            errs = 0;
        end else begin
            if (s_tvalid && s_tready) absorb_beat(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected digest beat: word %h index %0d last %b",
                                 m_tdata, m_tuser, m_tlast);
                end else begin
                    exp_beat = digest_q.pop_front();
                    if (m_tdata !== exp_beat.word || m_tuser !== exp_beat.index ||
                        m_tlast !== exp_beat.last) begin
                        errs++;
                        if (errs <= 10)
                            $display({"digest beat mismatch: expected word %h index %0d",
                                      " last %b, got word %h index %0d last %b"},
                                     exp_beat.word, exp_beat.index, exp_beat.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
            end
        end
        words_pending <= digest_q.size();
        fail_count    <= errs;
    end

endmodule

// ===== tb/sv/sha1_message_digest_top_test.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the SHA-1 message digest block: sends messages
// byte by byte and lets sha1_digest_checker judge the digests. Needs the RTL.

module sha1_message_digest_top_test;

    localparam int ITEM_TARGET  = 370;   // counted beats, ignored beats excluded
    localparam int QUIET_ITEMS  = 60;    // tail of the run with no idling
    localparam int DRAIN_CYCLES = 400;   // > padding + two compressions
    localparam int HOLD_CYCLES  = 700;   // long receiver hold-off
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int words_pending;
    int items_sent = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;        // set for the last part: no idling on either side
    bit hold_armed = 1'b0;   // allows the one long receiver hold-off
    bit hold_done = 1'b0;

    sha1_message_digest_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha1_digest_checker u_digest_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: fails the run if it reaches CYCLE_LIMIT.
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Offers one beat, after an optional idle burst, and waits for the
    // handshake. tvalid stays high into the next beat unless a burst follows,
    // so it is never lowered and raised in the same step.
    task automatic send_beat(input logic [7:0] value, input logic present,
                             input logic eom);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= present;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Sender stops and waits until every digest word predicted so far has
    // been taken. The first edge lets the checker's count catch up with an
    // end beat taken at the current edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random message; ignored beats (no byte, no end) are sprinkled in as
    // noise. The end comes either on the last byte or as an end-only beat.
    task automatic send_message(input int len, input bit eom_on_byte);
        logic [7:0] value;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            value = 8'($urandom);
            send_beat(value, 1'b1, eom_on_byte && (i == len - 1));
            items_sent++;
        end
        if (!eom_on_byte || len == 0) begin
            send_beat(8'($urandom), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    // Mostly short messages; now and then a length around the padding
    // boundaries (55/56 bytes into a block) or the block boundaries.
    function automatic int pick_length();
        int boundary_len [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        if ($urandom_range(0, 9) < 3) return boundary_len[$urandom_range(0, 9)];
        return $urandom_range(0, 30);
    endfunction

    // Receiver: random stall bursts, plain stretches, and once a long
    // hold-off while a digest waits, so that s_tready stays low and the
    // sender's next message piles up behind it.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_armed && !hold_done && m_tvalid) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        bit paused;
        int len;
        paused = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message by an end-only beat with its byte field
        // all ones (must be ignored).
        send_beat(8'hFF, 1'b0, 1'b1);
        // Ignored beat, then "abc" with the end on the last byte.
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        // Single zero byte with the end in the same beat.
        send_beat(8'h00, 1'b1, 1'b1);
        // Single 0xFF byte, end-only beat with a zero byte field.
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // Ignored beats at both byte extremes between messages.
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        // Four 0xFF bytes, a zero byte carrying the end.
        repeat (4) send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        items_sent = 12;

        // Pause with everything drained, then allow the long hold-off.
        wait_drained();
        hold_armed = 1'b1;

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
            if (!paused && items_sent >= ITEM_TARGET / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            len = pick_length();
            if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
            send_message(len, 1'($urandom_range(0, 1)));
        end

        // Drain and give a stray beat time to show up.
        wait_drained();

        if (fail_count == 0 && words_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sha1md_pkg.sv
sv/sha1md_sched_mem.sv
sv/sha1md_round.sv
sv/sha1md_top.sv
tb/sv/sha1_digest_checker.sv
tb/sv/sha1_message_digest_top_test.sv
